### src/scal_pkg.sv
// shared types and codes for the sensor calibration interpolator
// command and status codes, transaction structs and default sizes
// no dependencies
`default_nettype none

package scal_pkg;

  localparam int DEF_POINTS   = 16;
  localparam int DEF_RAW_BITS = 12;
  localparam int ANGLE_W      = 16;

  localparam logic [1:0] CMD_CLEAR   = 2'd0;
  localparam logic [1:0] CMD_INSERT  = 2'd1;
  localparam logic [1:0] CMD_CONVERT = 2'd2;

  localparam logic [2:0] ST_INTERP  = 3'd0;
  localparam logic [2:0] ST_LOW     = 3'd1;
  localparam logic [2:0] ST_HIGH    = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_STORED  = 3'd4;
  localparam logic [2:0] ST_FULL    = 3'd5;
  localparam logic [2:0] ST_CLEARED = 3'd6;

  localparam logic signed [ANGLE_W-1:0] EMPTY_ANGLE = -16'sd64;

  typedef struct packed {
    logic [1:0]                command;
    logic                      channel;
    logic [11:0]               raw_sample;
    logic signed [ANGLE_W-1:0] point_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic [2:0]                status;
  } out_item_t;

endpackage

`default_nettype wire

### src/scal_div.sv
// iterative unsigned restoring divider, one quotient bit per cycle
// requires num < den * 2**Q_W; no package dependency
`default_nettype none

module scal_div #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 12,
  parameter int Q_W   = 17
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [Q_W-1:0]        quot
);

  localparam int CW = $clog2(Q_W + 1);

  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [Q_W-1:0]   q_r;
  logic [CW-1:0]    cnt_r;
  logic             run_r;
  logic             done_r;

  logic [DEN_W:0] shifted;
  logic [DEN_W:0] diff;
  logic           ge;

  assign shifted = {rem_r, q_r[Q_W-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign ge      = !diff[DEN_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(Q_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // high numerator bits seed the remainder, they are already below den
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DEN_W'(num >> Q_W);
      q_r   <= num[Q_W-1:0];
      den_r <= den;
    end else if (run_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      q_r   <= {q_r[Q_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

`default_nettype wire

### src/sensor_calibration_interpolator_unit.sv
// top level of the two-channel calibration interpolator
// table memory, command sequencer and interpolation datapath
// depends on scal_pkg and scal_div
`default_nettype none

// Usage: a command transaction (in_item) is taken at a rising edge where
// start is high and busy is low. Commands: clear both tables, insert a
// (raw, angle) point into one channel's sorted table, or convert a raw
// reading to an angle. Every command but the unused code gives exactly one
// result, shown on out_item for a single cycle with out_valid high; the
// receiver cannot hold it off. busy is low again in that same cycle.
// Both tables share one single-port-read memory of 2*POINTS_PER_CHANNEL
// entries with a registered read; the sequencer walks it one entry a cycle.
// Clear, full insert, empty convert and first point insert answer without
// a memory read. Insert reads each point that it moves up, one memory read
// per point. Convert reads the first point and clamps low on it, else reads
// the last point and clamps high on it; an interpolated convert then scans
// the memory and waits for the 17-step iterative divider.
// One command is in flight at a time. Reset empties both tables through the
// point counts; the memory itself is not cleared.
module sensor_calibration_interpolator_unit
  import scal_pkg::*;
#(
  parameter int POINTS_PER_CHANNEL = DEF_POINTS,
  parameter int RAW_BITS           = DEF_RAW_BITS
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  output out_item_t      out_item
);

  localparam int P      = POINTS_PER_CHANNEL;
  localparam int DEPTH  = 2 * P;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = $clog2(P);
  localparam int CNT_W  = $clog2(P + 1);
  localparam int DA_W   = ANGLE_W + 1;
  localparam int PROD_W = RAW_BITS + 1 + DA_W;
  localparam int NUM_W  = RAW_BITS + ANGLE_W;
  localparam int Q_W    = ANGLE_W + 1;
  localparam int SUM_W  = ANGLE_W + 2;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS      = 3'd1;
  localparam logic [2:0] S_INS_PUT  = 3'd2;
  localparam logic [2:0] S_CV_FIRST = 3'd3;
  localparam logic [2:0] S_CV_LAST  = 3'd4;
  localparam logic [2:0] S_CV_SCAN  = 3'd5;
  localparam logic [2:0] S_CV_MUL   = 3'd6;
  localparam logic [2:0] S_CV_DIV   = 3'd7;

  typedef struct packed {
    logic [RAW_BITS-1:0]       raw;
    logic signed [ANGLE_W-1:0] angle;
  } ent_t;

  function automatic logic [ADDR_W-1:0] ent_addr(input logic ch,
                                                 input logic [IDX_W-1:0] idx);
    ent_addr = (ch ? ADDR_W'(P) : '0) + ADDR_W'(idx);
  endfunction

  // table memory
  ent_t              mem [DEPTH];
  ent_t              rd_data_r;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              we;
  logic [ADDR_W-1:0] wa;
  ent_t              wd;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  // control registers
  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r [2];
  logic [CNT_W-1:0] cnt_nxt [2];
  logic             out_valid_r, out_valid_nxt;

  // payload registers
  logic                      ch_r, ch_nxt;
  logic [RAW_BITS-1:0]       raw_r, raw_nxt;
  logic signed [ANGLE_W-1:0] ang_r, ang_nxt;
  logic [CNT_W-1:0]          n_r, n_nxt;
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  ent_t                      prev_r, prev_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic [RAW_BITS-1:0]       den_r, den_nxt;
  logic signed [ANGLE_W-1:0] a0_r, a0_nxt;
  out_item_t                 out_item_r, out_item_nxt;

  // interpolation datapath
  logic signed [RAW_BITS:0] dr;
  logic signed [DA_W-1:0]   da;
  logic signed [PROD_W-1:0] prod_calc;
  logic [NUM_W-1:0]         mag;
  logic                     div_start;
  logic                     div_done;
  logic [Q_W-1:0]           div_q;
  logic signed [SUM_W-1:0]  qx;
  logic signed [SUM_W-1:0]  sum;

  assign dr        = {1'b0, raw_r - prev_r.raw};
  assign da        = {rd_data_r.angle[ANGLE_W-1], rd_data_r.angle}
                   - {prev_r.angle[ANGLE_W-1], prev_r.angle};
  assign prod_calc = dr * da;
  assign mag       = prod_r[PROD_W-1] ? NUM_W'(-prod_r) : NUM_W'(prod_r);
  assign qx        = SUM_W'(div_q);
  // truncation toward zero: divide the magnitude, then restore the sign
  assign sum       = {{2{a0_r[ANGLE_W-1]}}, a0_r}
                   + (prod_r[PROD_W-1] ? -qx : qx);

  scal_div #(
    .NUM_W (NUM_W),
    .DEN_W (RAW_BITS),
    .Q_W   (Q_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (mag),
    .den   (den_r),
    .done  (div_done),
    .quot  (div_q)
  );

  always_comb begin
    logic                ch_in;
    logic [RAW_BITS-1:0] raw_in;
    logic [CNT_W-1:0]    n_in;
    ch_in         = in_item.channel;
    raw_in        = RAW_BITS'(in_item.raw_sample);
    n_in          = cnt_r[ch_in];
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = '0;
    ch_nxt        = ch_r;
    raw_nxt       = raw_r;
    ang_nxt       = ang_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    prev_nxt      = prev_r;
    prod_nxt      = prod_r;
    den_nxt       = den_r;
    a0_nxt        = a0_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    we            = 1'b0;
    wa            = '0;
    wd            = '0;
    div_start     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ch_nxt  = ch_in;
          raw_nxt = raw_in;
          ang_nxt = in_item.point_angle;
          n_nxt   = n_in;
          unique case (in_item.command)
            CMD_CLEAR: begin
              cnt_nxt[0]          = '0;
              cnt_nxt[1]          = '0;
              out_valid_nxt       = 1'b1;
              out_item_nxt.status = ST_CLEARED;
            end
            CMD_INSERT: begin
              if (n_in == CNT_W'(P)) begin
                out_valid_nxt       = 1'b1;
                out_item_nxt.status = ST_FULL;
              end else if (n_in == '0) begin
                we                  = 1'b1;
                wa                  = ent_addr(ch_in, '0);
                wd.raw              = raw_in;
                wd.angle            = in_item.point_angle;
                cnt_nxt[ch_in]      = CNT_W'(1);
                out_valid_nxt       = 1'b1;
                out_item_nxt.status = ST_STORED;
              end else begin
                rd_en     = 1'b1;
                idx_nxt   = IDX_W'(n_in - 1'b1);
                rd_addr   = ent_addr(ch_in, IDX_W'(n_in - 1'b1));
                state_nxt = S_INS;
              end
            end
            CMD_CONVERT: begin
              if (n_in == '0) begin
                out_valid_nxt       = 1'b1;
                out_item_nxt.angle  = EMPTY_ANGLE;
                out_item_nxt.status = ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = ent_addr(ch_in, '0);
                state_nxt = S_CV_FIRST;
              end
            end
            default: begin
            end
          endcase
        end
      end
      // walk down from the last point, moving larger keys up one slot
      S_INS: begin
        we = 1'b1;
        wa = ent_addr(ch_r, idx_r + 1'b1);
        if (rd_data_r.raw > raw_r) begin
          wd = rd_data_r;
          if (idx_r == '0) begin
            state_nxt = S_INS_PUT;
          end else begin
            rd_en   = 1'b1;
            idx_nxt = idx_r - 1'b1;
            rd_addr = ent_addr(ch_r, idx_r - 1'b1);
          end
        end else begin
          wd.raw              = raw_r;
          wd.angle            = ang_r;
          cnt_nxt[ch_r]       = n_r + 1'b1;
          out_valid_nxt       = 1'b1;
          out_item_nxt.status = ST_STORED;
          state_nxt           = S_IDLE;
        end
      end
      S_INS_PUT: begin
        we                  = 1'b1;
        wa                  = ent_addr(ch_r, '0);
        wd.raw              = raw_r;
        wd.angle            = ang_r;
        cnt_nxt[ch_r]       = n_r + 1'b1;
        out_valid_nxt       = 1'b1;
        out_item_nxt.status = ST_STORED;
        state_nxt           = S_IDLE;
      end
      S_CV_FIRST: begin
        if (raw_r <= rd_data_r.raw) begin
          out_valid_nxt       = 1'b1;
          out_item_nxt.angle  = rd_data_r.angle;
          out_item_nxt.status = ST_LOW;
          state_nxt           = S_IDLE;
        end else begin
          prev_nxt  = rd_data_r;
          rd_en     = 1'b1;
          rd_addr   = ent_addr(ch_r, IDX_W'(n_r - 1'b1));
          state_nxt = S_CV_LAST;
        end
      end
      S_CV_LAST: begin
        if (raw_r >= rd_data_r.raw) begin
          out_valid_nxt       = 1'b1;
          out_item_nxt.angle  = rd_data_r.angle;
          out_item_nxt.status = ST_HIGH;
          state_nxt           = S_IDLE;
        end else begin
          rd_en     = 1'b1;
          idx_nxt   = IDX_W'(1);
          rd_addr   = ent_addr(ch_r, IDX_W'(1));
          state_nxt = S_CV_SCAN;
        end
      end
      // raw lies strictly inside the table, so the scan always ends
      S_CV_SCAN: begin
        if (raw_r <= rd_data_r.raw) begin
          prod_nxt  = prod_calc;
          den_nxt   = rd_data_r.raw - prev_r.raw;
          a0_nxt    = prev_r.angle;
          state_nxt = S_CV_MUL;
        end else begin
          prev_nxt = rd_data_r;
          rd_en    = 1'b1;
          idx_nxt  = idx_r + 1'b1;
          rd_addr  = ent_addr(ch_r, idx_r + 1'b1);
        end
      end
      S_CV_MUL: begin
        div_start = 1'b1;
        state_nxt = S_CV_DIV;
      end
      S_CV_DIV: begin
        if (div_done) begin
          out_valid_nxt       = 1'b1;
          out_item_nxt.angle  = ANGLE_W'(sum);
          out_item_nxt.status = ST_INTERP;
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r[0]    <= '0;
      cnt_r[1]    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r       <= ch_nxt;
    raw_r      <= raw_nxt;
    ang_r      <= ang_nxt;
    n_r        <= n_nxt;
    idx_r      <= idx_nxt;
    prev_r     <= prev_nxt;
    prod_r     <= prod_nxt;
    den_r      <= den_nxt;
    a0_r       <= a0_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[0] <= CNT_W'(P) && cnt_r[1] <= CNT_W'(P))
    else $error("point count above table size");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_CV_DIV)
    else $error("divider finished outside convert");

  a_rw_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (we && rd_en) |-> wa != rd_addr)
    else $error("memory read and write hit the same entry");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_IDLE)
    else $error("result strobe while a transaction is still running");

endmodule

`default_nettype wire
